// ----- rtl/gmdfs_pkg.sv -----
// Shared types, constants and command/status structs for the grid maze DFS core.
package gmdfs_pkg;

    localparam int GRID_DIM   = 64;
    localparam int COORD_W    = 6;
    localparam int CELL_COUNT = GRID_DIM * GRID_DIM;
    localparam int IDX_W      = 12;
    localparam int CNT_W      = 13;
    localparam logic [CNT_W-1:0] COUNT_MAX = 13'd8191;

    // Cell marks: open and unvisited, on the current route, backtracked.
    localparam logic [1:0] MARK_OPEN  = 2'd0;
    localparam logic [1:0] MARK_ROUTE = 2'd1;
    localparam logic [1:0] MARK_BACK  = 2'd2;

    typedef enum logic [2:0] {
        DIR_NONE  = 3'd0,
        DIR_EAST  = 3'd1,
        DIR_SOUTH = 3'd2,
        DIR_WEST  = 3'd3,
        DIR_NORTH = 3'd4,
        DIR_DONE  = 3'd5
    } dir_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic load_wall;    // write wall bit of the latched load cell
        logic latch_req;    // capture the incoming item fields
        logic clr_step;     // write one entry of the clearing sweep
        logic clr_reset;    // restart the clearing sweep counter
        logic start_rd;     // read wall bits of start and goal
        logic start_push;   // push start cell, reset counters
        logic top_rd;       // read top of stack and its direction
        logic probe_rd;     // read neighbour in the current direction
        logic probe_eval;   // decide on the probed neighbour
        logic fail_zero;    // zero counters (wall start/goal)
        logic out_load;     // load output register
        logic out_found;    // found flag for the output
    } gmdfs_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic clr_done;
        logic start_bad;    // start or goal is a wall
        logic at_goal;      // top of stack is the goal
        logic stack_empty;
        logic probe_ok;     // probed neighbour is open and unvisited
        logic dir_done;     // current direction reached the end
    } gmdfs_sts_t;

endpackage

// ----- rtl/grid_maze_dfs_path_search_core.sv -----
// Top level of the grid maze depth-first path search core.
// This core holds a 64 x 64 grid of wall bits and answers path queries by a
// depth-first search with an explicit stack, trying east, south, west and
// north in that order. A load item (s_tuser = 0) writes one wall bit and
// gives no result. A run item (s_tuser = 1) gives one result item. Each run
// first sweeps the mark and direction memories, one cell per cycle, then
// walks: each direction probe reads the wall and mark memories, and each
// advance or backtrack then reads the stack and direction memories again
// before the next probe, since the stack, mark and direction memories each
// have a single registered read port. Every cell of the grid must be loaded
// before it is searched. One item is worked on at a time; the next is
// accepted once the current one is done and its result, if any, has been taken.
module grid_maze_dfs_path_search_core
    import gmdfs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata: cell_x[5:0], cell_y[11:6], is_wall[12], start_x[18:13],
    // start_y[24:19], goal_x[30:25], goal_y[36:31], zero fill [39:37]
    input  logic [39:0] s_tdata,
    // tuser: req_type (0 load a wall bit, 1 run a search)
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata: found[0], path_length[13:1], advance_count[26:14],
    // backtrack_count[39:27]
    output logic [39:0] m_tdata
);

    gmdfs_cmd_t cmd;
    gmdfs_sts_t sts;

    logic             res_found;
    logic [CNT_W-1:0] res_path_length;
    logic [CNT_W-1:0] res_advance_count;
    logic [CNT_W-1:0] res_backtrack_count;

    gmdfs_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_run    (s_tuser),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cmd       (cmd),
        .sts       (sts)
    );

    gmdfs_datapath u_datapath (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cmd                 (cmd),
        .sts                 (sts),
        .in_cell_x           (s_tdata[5:0]),
        .in_cell_y           (s_tdata[11:6]),
        .in_is_wall          (s_tdata[12]),
        .in_start_x          (s_tdata[18:13]),
        .in_start_y          (s_tdata[24:19]),
        .in_goal_x           (s_tdata[30:25]),
        .in_goal_y           (s_tdata[36:31]),
        .res_found           (res_found),
        .res_path_length     (res_path_length),
        .res_advance_count   (res_advance_count),
        .res_backtrack_count (res_backtrack_count)
    );

    assign m_tdata = {res_backtrack_count, res_advance_count, res_path_length, res_found};

endmodule

// ----- rtl/gmdfs_datapath.sv -----
// Datapath of the grid maze DFS core: grid memories, stack, counters and result register.
module gmdfs_datapath
    import gmdfs_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  gmdfs_cmd_t          cmd,
    output gmdfs_sts_t          sts,
    input  logic [COORD_W-1:0]  in_cell_x,
    input  logic [COORD_W-1:0]  in_cell_y,
    input  logic                in_is_wall,
    input  logic [COORD_W-1:0]  in_start_x,
    input  logic [COORD_W-1:0]  in_start_y,
    input  logic [COORD_W-1:0]  in_goal_x,
    input  logic [COORD_W-1:0]  in_goal_y,
    output logic                res_found,
    output logic [CNT_W-1:0]    res_path_length,
    output logic [CNT_W-1:0]    res_advance_count,
    output logic [CNT_W-1:0]    res_backtrack_count
);

    // Memories. Mark holds open, route or backtracked.
    logic             wall_mem  [CELL_COUNT];
    logic [1:0]       mark_mem  [CELL_COUNT];
    logic [2:0]       dir_mem   [CELL_COUNT];
    logic [IDX_W-1:0] stack_mem [CELL_COUNT];

    logic [COORD_W-1:0] cx_reg, cy_reg, sx_reg, sy_reg, gx_reg, gy_reg;
    logic               wall_reg;
    logic [IDX_W-1:0]   clr_reg;
    logic               clr_done_reg;
    logic [CNT_W-1:0]   depth_reg, adv_reg, back_reg;
    logic [IDX_W-1:0]   top_reg;      // top cell index
    logic [2:0]         dir_reg;      // direction under test
    logic [IDX_W-1:0]   nb_reg;       // neighbour index
    logic               nb_in_reg;    // neighbour inside the grid
    logic               nb_wall_reg;
    logic [1:0]         nb_mark_reg;
    logic               sw_reg, gw_reg;
    logic               top_valid_reg; // top-of-stack read pending capture
    logic [IDX_W-1:0]   stack_q_reg;
    logic [2:0]         dir_q_reg;

    logic [IDX_W-1:0] s_idx, g_idx, c_idx;
    logic [COORD_W-1:0] tx, ty;
    logic [2:0]         dir_try;
    logic [IDX_W-1:0]   nb_next;
    logic               nb_in_next;

    assign s_idx = {sy_reg, sx_reg};
    assign g_idx = {gy_reg, gx_reg};
    assign c_idx = {cy_reg, cx_reg};
    assign tx = top_reg[COORD_W-1:0];
    assign ty = top_reg[IDX_W-1:COORD_W];

    // Next direction to try from the stored one.
    assign dir_try = (dir_reg >= DIR_DONE) ? DIR_DONE : dir_reg + 3'd1;

    always_comb begin
        nb_next    = top_reg;
        nb_in_next = 1'b0;
        unique case (dir_try)
            DIR_EAST: begin
                nb_in_next = (tx != COORD_W'(GRID_DIM - 1));
                nb_next    = {ty, tx + COORD_W'(1)};
            end
            DIR_SOUTH: begin
                nb_in_next = (ty != COORD_W'(GRID_DIM - 1));
                nb_next    = {ty + COORD_W'(1), tx};
            end
            DIR_WEST: begin
                nb_in_next = (tx != '0);
                nb_next    = {ty, tx - COORD_W'(1)};
            end
            DIR_NORTH: begin
                nb_in_next = (ty != '0);
                nb_next    = {ty - COORD_W'(1), tx};
            end
            default: begin
                nb_in_next = 1'b0;
                nb_next    = top_reg;
            end
        endcase
    end

    // Wall memory: one write port, two read ports (start and goal are read together).
    always_ff @(posedge aclk) begin
        if (cmd.load_wall) begin
            wall_mem[c_idx] <= wall_reg;
        end
        if (cmd.start_rd) begin
            sw_reg <= wall_mem[s_idx];
        end else if (cmd.probe_rd) begin
            nb_wall_reg <= wall_mem[nb_next];
        end
        if (cmd.start_rd) begin
            gw_reg <= wall_mem[g_idx];
        end
    end

    // Mark memory.
    always_ff @(posedge aclk) begin
        if (cmd.clr_step) begin
            mark_mem[clr_reg] <= MARK_OPEN;
        end else if (cmd.start_push) begin
            mark_mem[s_idx] <= MARK_ROUTE;
        end else if (cmd.probe_eval) begin
            if (dir_reg == DIR_DONE) begin
                mark_mem[top_reg] <= MARK_BACK;
            end else if (nb_in_reg && !nb_wall_reg && nb_mark_reg == MARK_OPEN) begin
                mark_mem[nb_reg] <= MARK_ROUTE;
            end
        end
        if (cmd.probe_rd) begin
            nb_mark_reg <= mark_mem[nb_next];
        end
    end

    // Direction memory.
    always_ff @(posedge aclk) begin
        if (cmd.clr_step) begin
            dir_mem[clr_reg] <= DIR_NONE;
        end else if (cmd.probe_eval) begin
            if (dir_reg != DIR_DONE && nb_in_reg && !nb_wall_reg
                && nb_mark_reg == MARK_OPEN) begin
                dir_mem[nb_reg] <= DIR_NONE;
            end
        end else if (cmd.probe_rd) begin
            dir_mem[top_reg] <= dir_try;
        end
        if (cmd.top_rd) begin
            dir_q_reg <= dir_mem[stack_q_reg];
        end
    end

    // Stack memory; read address is depth-1, and the read is registered into stack_q_reg.
    always_ff @(posedge aclk) begin
        if (cmd.start_push) begin
            stack_mem[0] <= s_idx;
        end else if (cmd.probe_eval && dir_reg != DIR_DONE && nb_in_reg && !nb_wall_reg
                     && nb_mark_reg == MARK_OPEN) begin
            stack_mem[depth_reg[IDX_W-1:0]] <= nb_reg;
        end
        stack_q_reg <= stack_mem[depth_reg[IDX_W-1:0] - IDX_W'(1)];
    end

    // Registers with control meaning.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg       <= '0;
            clr_done_reg  <= 1'b0;
            depth_reg     <= '0;
            adv_reg       <= '0;
            back_reg      <= '0;
            top_valid_reg <= 1'b0;
            res_found     <= 1'b0;
        end else begin
            if (cmd.clr_reset) begin
                clr_reg      <= '0;
                clr_done_reg <= 1'b0;
            end else if (cmd.clr_step) begin
                clr_reg      <= clr_reg + IDX_W'(1);
                clr_done_reg <= (clr_reg == IDX_W'(CELL_COUNT - 1));
            end
            top_valid_reg <= cmd.top_rd;
            if (cmd.start_push) begin
                depth_reg <= CNT_W'(1);
                adv_reg   <= '0;
                back_reg  <= '0;
            end else if (cmd.fail_zero) begin
                depth_reg <= '0;
                adv_reg   <= '0;
                back_reg  <= '0;
            end else if (cmd.probe_eval) begin
                if (dir_reg == DIR_DONE) begin
                    depth_reg <= depth_reg - CNT_W'(1);
                    back_reg  <= back_reg + CNT_W'(1);
                end else if (nb_in_reg && !nb_wall_reg && nb_mark_reg == MARK_OPEN) begin
                    depth_reg <= depth_reg + CNT_W'(1);
                    adv_reg   <= adv_reg + CNT_W'(1);
                end
            end
            if (cmd.out_load) begin
                res_found <= cmd.out_found;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (cmd.latch_req) begin
            cx_reg   <= in_cell_x;
            cy_reg   <= in_cell_y;
            wall_reg <= in_is_wall;
            sx_reg   <= in_start_x;
            sy_reg   <= in_start_y;
            gx_reg   <= in_goal_x;
            gy_reg   <= in_goal_y;
        end
        if (top_valid_reg) begin
            top_reg <= stack_q_reg;
            dir_reg <= dir_q_reg;
        end else if (cmd.probe_rd) begin
            dir_reg   <= dir_try;
            nb_reg    <= nb_next;
            nb_in_reg <= nb_in_next;
        end
        if (cmd.out_load) begin
            res_path_length     <= cmd.out_found ? depth_reg : '0;
            res_advance_count   <= adv_reg;
            res_backtrack_count <= back_reg;
        end
    end

    assign sts.clr_done    = clr_done_reg;
    assign sts.start_bad   = sw_reg | gw_reg;
    assign sts.at_goal     = (top_reg == g_idx);
    assign sts.stack_empty = (depth_reg == '0);
    assign sts.probe_ok    = nb_in_reg && !nb_wall_reg && (nb_mark_reg == MARK_OPEN);
    assign sts.dir_done    = (dir_reg == DIR_DONE);

endmodule

// ----- rtl/gmdfs_ctrl.sv -----
// Controller state machine of the grid maze DFS core.
module gmdfs_ctrl
    import gmdfs_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       in_run,
    output logic       out_valid,
    input  logic       out_ready,
    output gmdfs_cmd_t cmd,
    input  gmdfs_sts_t sts
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_LOAD, ST_CLEAR, ST_START, ST_CHECK, ST_TOP0, ST_TOP1, ST_TOP2,
        ST_PROBE, ST_EVAL, ST_DONE, ST_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg;

    assign in_ready  = (state_reg == ST_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid && in_ready) begin
                    cmd.latch_req = 1'b1;
                    cmd.clr_reset = 1'b1;
                    state_next    = in_run ? ST_CLEAR : ST_LOAD;
                end
            end
            ST_LOAD: begin
                cmd.load_wall = 1'b1;
                state_next    = ST_IDLE;
            end
            ST_CLEAR: begin
                if (sts.clr_done) begin
                    cmd.start_rd = 1'b1;
                    state_next   = ST_START;
                end else begin
                    cmd.clr_step = 1'b1;
                end
            end
            ST_START: begin
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (sts.start_bad) begin
                    cmd.fail_zero = 1'b1;
                    state_next    = ST_DONE;
                end else begin
                    cmd.start_push = 1'b1;
                    state_next     = ST_TOP0;
                end
            end
            ST_TOP0: begin
                // stack read address settles on the new depth
                state_next = ST_TOP1;
            end
            ST_TOP1: begin
                if (sts.stack_empty) begin
                    state_next = ST_DONE;
                end else begin
                    cmd.top_rd = 1'b1;
                    state_next = ST_TOP2;
                end
            end
            ST_TOP2: begin
                state_next = ST_PROBE;
            end
            ST_PROBE: begin
                if (sts.at_goal) begin
                    cmd.out_load  = 1'b1;
                    cmd.out_found = 1'b1;
                    state_next    = ST_OUT;
                end else begin
                    cmd.probe_rd = 1'b1;
                    state_next   = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (sts.dir_done || sts.probe_ok) begin
                    cmd.probe_eval = 1'b1;
                    state_next     = ST_TOP0;
                end else begin
                    cmd.probe_rd = 1'b1;
                end
            end
            ST_DONE: begin
                cmd.out_load = 1'b1;
                state_next   = ST_OUT;
            end
            ST_OUT: begin
                if (out_valid_reg && out_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (out_valid_reg && out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ----- tb/sv/gmdfs_checker.sv -----
// Scoreboard for the grid maze search core: predicts every search result and compares it.
`timescale 1ns / 1ps

module gmdfs_checker
    import gmdfs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,
    output int          pending,
    output int          errors
);

    typedef enum logic [1:0] {
        CELL_OPEN  = 2'd0,
        CELL_ROUTE = 2'd1,
        CELL_BACK  = 2'd2
    } mark_t;

    // Laid out as on m_tdata, found in the lowest bit.
    typedef struct packed {
        logic [CNT_W-1:0] backtracks;
        logic [CNT_W-1:0] advances;
        logic [CNT_W-1:0] path_len;
        logic             found;
    } search_res_t;

    bit          wall_bits [CELL_COUNT];
    mark_t       marks     [CELL_COUNT];
    dir_t        tried     [CELL_COUNT];
    int          route     [CELL_COUNT];
    search_res_t search_results_q[$];

    function automatic logic [CNT_W-1:0] clip(int v);
        return (v > COUNT_MAX) ? COUNT_MAX : CNT_W'(v);
    endfunction

    // Neighbor of a cell in one direction; -1 if it lies off the grid.
    function automatic int neighbor(int idx, dir_t d);
        int x;
        int y;
        x = idx % GRID_DIM;
        y = idx / GRID_DIM;
        case (d)
            DIR_EAST:  x = x + 1;
            DIR_SOUTH: y = y + 1;
            DIR_WEST:  x = x - 1;
            DIR_NORTH: y = y - 1;
            default:   return -1;
        endcase
        if (x < 0 || y < 0 || x >= GRID_DIM || y >= GRID_DIM) return -1;
        return y * GRID_DIM + x;
    endfunction

    function automatic search_res_t walk_maze(int sx, int sy, int gx, int gy);
        search_res_t r;
        int depth;
        int adv;
        int bak;
        int s;
        int g;
        int c;
        int n;
        dir_t d;
        r = '0;
        depth = 0;
        adv = 0;
        bak = 0;
        foreach (marks[i]) begin
            marks[i] = CELL_OPEN;
            tried[i] = DIR_NONE;
        end
        s = sy * GRID_DIM + sx;
        g = gy * GRID_DIM + gx;
        if (wall_bits[s] || wall_bits[g]) return r;
        route[0] = s;
        depth = 1;
        marks[s] = CELL_ROUTE;
        while (depth > 0) begin
            c = route[depth-1];
            if (c == g) begin
                r.found = 1'b1;
                r.path_len = clip(depth);
                r.advances = clip(adv);
                r.backtracks = clip(bak);
                return r;
            end
            d = tried[c];
            n = -1;
            forever begin
                d = (d >= DIR_DONE) ? DIR_DONE : dir_t'(d + 1);
                if (d == DIR_DONE) break;
                n = neighbor(c, d);
                if (n >= 0 && !wall_bits[n] && marks[n] == CELL_OPEN) break;
            end
            tried[c] = d;
            if (d == DIR_DONE) begin
                marks[c] = CELL_BACK;
                depth--;
                bak++;
            end else begin
                route[depth] = n;
                depth++;
                tried[n] = DIR_NONE;
                marks[n] = CELL_ROUTE;
                adv++;
            end
        end
        r.advances = clip(adv);
        r.backtracks = clip(bak);
        return r;
    endfunction

    assign pending = search_results_q.size();

    always @(posedge aclk) begin
        search_res_t exp_r;
        search_res_t got;
        if (!aresetn) begin
            errors <= 0;
        end else begin
            // A load writes the wall bit; a run predicts one result.
            if (s_tvalid && s_tready) begin
                if (!s_tuser)
                    wall_bits[int'(s_tdata[11:6]) * GRID_DIM + int'(s_tdata[5:0])] =
                        s_tdata[12];
                else
                    search_results_q.push_back(walk_maze(int'(s_tdata[18:13]),
                                                         int'(s_tdata[24:19]),
                                                         int'(s_tdata[30:25]),
                                                         int'(s_tdata[36:31])));
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (search_results_q.size() == 0) begin
                    $display("%0t: result with nothing expected, actual %h", $time, m_tdata);
                    errors <= errors + 1;
                end else begin
                    exp_r = search_results_q.pop_front();
                    if (got.found !== exp_r.found || got.path_len !== exp_r.path_len ||
                        got.advances !== exp_r.advances ||
                        got.backtracks !== exp_r.backtracks) begin
                        $display("%0t: mismatch expected found %0d len %0d adv %0d back %0d",
                                 $time, exp_r.found, exp_r.path_len, exp_r.advances,
                                 exp_r.backtracks);
                        $display("%0t:          actual found %0d len %0d adv %0d back %0d",
                                 $time, got.found, got.path_len, got.advances,
                                 got.backtracks);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end

endmodule

// ----- tb/sv/tb_top.sv -----
// Stimulus and verdict for the grid maze search core testbench.
`timescale 1ns / 1ps

module tb_top;
    import gmdfs_pkg::*;

    localparam int RANDOM_ITEMS = 1280;
    localparam int QUIET_ITEMS  = 150;
    localparam longint LIMIT    = 8000000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    int          pending;
    int          errors;

    // Idling on both sides is enabled for most of the run.
    bit     idle_en = 1'b1;
    // A pulse that asks the receiver for one long hold-off.
    bit     long_hold = 1'b0;
    longint cycles = 0;
    // Cells whose wall bit has been written at least once.
    bit     loaded [CELL_COUNT];

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    grid_maze_dfs_path_search_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    gmdfs_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .pending(pending), .errors(errors)
    );

    // Open cells are kept inside two 8 x 8 corner windows so that every walk
    // stays short, since each search already sweeps all 4096 cells in its
    // clearing sweep. Only the windows and the ring of walls around them are
    // loaded at the start; searches never touch any other cell until it has
    // been written.
    function automatic bit in_window(int x, int y);
        return (x < 8 && y < 8) || (x >= 56 && y >= 56);
    endfunction

    // A window cell or one of its direct neighbors outside the window.
    function automatic bit near_window(int x, int y);
        return (x < 9 && y < 9 && !(x == 8 && y == 8)) ||
               (x >= 55 && y >= 55 && !(x == 55 && y == 55));
    endfunction

    // Pick a coordinate inside window zero (low corner) or one (high corner).
    function automatic int win_coord(bit hi);
        return hi ? $urandom_range(56, 63) : $urandom_range(0, 7);
    endfunction

    // A random cell anywhere if it has been loaded, else a window cell.
    task automatic any_cell(output int x, output int y);
        bit hi;
        x = $urandom_range(0, 63);
        y = $urandom_range(0, 63);
        if (!loaded[y * GRID_DIM + x]) begin
            hi = 1'($urandom_range(0, 1));
            x = win_coord(hi);
            y = win_coord(hi);
        end
    endtask

    // Send one item and hold it until the core takes it. Idle gaps are
    // inserted before the item, never between acceptance and the next
    // raise of tvalid in the same time step.
    task automatic send_item(bit user, logic [39:0] data);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 40'({$urandom, $urandom});
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= user;
        s_tdata  <= data;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Load item: the search fields carry random noise, which the core ignores.
    task automatic load_cell(int x, int y, bit wall);
        logic [39:0] d;
        d = 40'({$urandom, $urandom});
        d[39:37] = '0;
        d[5:0]   = 6'(x);
        d[11:6]  = 6'(y);
        d[12]    = wall;
        loaded[y * GRID_DIM + x] = 1'b1;
        send_item(1'b0, d);
    endtask

    // Run item: the cell fields carry noise.
    task automatic run_search(int sx, int sy, int gx, int gy);
        logic [39:0] d;
        d = 40'({$urandom, $urandom});
        d[39:37] = '0;
        d[18:13] = 6'(sx);
        d[24:19] = 6'(sy);
        d[30:25] = 6'(gx);
        d[36:31] = 6'(gy);
        send_item(1'b1, d);
    endtask

    // Stop offering and wait until the last accepted item has been scored
    // and every expected result has come.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    // Receiver: random short stalls, plus one long hold-off on request.
    initial begin
        int stall;
        stall = 0;
        forever begin
            @(posedge aclk);
            if (long_hold)
                stall = 12000;
            else if (stall != 0)
                stall--;
            else if (idle_en && $urandom_range(0, 4) == 0)
                stall = $urandom_range(1, 3);
            m_tready <= (stall == 0);
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        bit hi;
        int x;
        int y;
        int sx;
        int sy;
        int gx;
        int gy;
        int sel;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Windows start mostly open; the ring around them is all walls.
        for (int cy = 0; cy < GRID_DIM; cy++)
            for (int cx = 0; cx < GRID_DIM; cx++)
                if (near_window(cx, cy))
                    load_cell(cx, cy,
                              in_window(cx, cy) ? ($urandom_range(0, 9) < 3) : 1'b1);

        // Directed part. Open both corner cells and a straight corridor.
        load_cell(0, 0, 1'b0);
        load_cell(63, 63, 1'b0);
        load_cell(20, 20, 1'b1);
        for (int i = 0; i < 8; i++) load_cell(i, 0, 1'b0);
        run_search(0, 0, 0, 0);       // start equals goal
        run_search(63, 63, 63, 63);   // start equals goal at the far corner
        run_search(0, 0, 7, 0);       // straight east run
        run_search(7, 0, 0, 0);       // westward run
        run_search(20, 20, 0, 0);     // start is a wall
        run_search(0, 0, 20, 20);     // goal is a wall
        run_search(0, 0, 63, 63);     // goal unreachable across walls
        load_cell(1, 0, 1'b1);        // block the corridor
        run_search(0, 0, 7, 0);
        load_cell(1, 0, 1'b0);
        run_search(63, 63, 56, 56);
        run_search(56, 63, 63, 56);

        // Hold the receiver off while more searches are offered, so the
        // core fills up and stalls its input.
        @(posedge aclk);
        long_hold <= 1'b1;
        @(posedge aclk);
        long_hold <= 1'b0;
        run_search(0, 0, 7, 7);
        run_search(63, 63, 56, 56);
        run_search(0, 0, 7, 0);
        drain();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 2) drain();
            if (n == RANDOM_ITEMS - QUIET_ITEMS) idle_en = 1'b0;
            hi = 1'($urandom_range(0, 1));
            sel = $urandom_range(0, 99);
            if (sel < 7) begin
                // Search inside one window, where most paths exist.
                run_search(win_coord(hi), win_coord(hi), win_coord(hi), win_coord(hi));
            end else if (sel < 9) begin
                any_cell(sx, sy);
                any_cell(gx, gy);
                run_search(sx, sy, gx, gy);
            end else if (sel < 60) begin
                // Reshape a window; open cells are more likely than walls.
                load_cell(win_coord(hi), win_coord(hi), $urandom_range(0, 9) < 4);
            end else begin
                // A wall written anywhere; inside a window it also closes cells.
                x = $urandom_range(0, 63);
                y = $urandom_range(0, 63);
                load_cell(x, y, 1'b1);
            end
        end

        drain();
        repeat (50) @(posedge aclk);
        if (errors == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
